FILE: src/ptfr_pkg.sv
// ----------------------------------------------------------------------------
// ptfr_pkg
// Types and constants shared by the frequency page table blocks.
// ----------------------------------------------------------------------------
package ptfr_pkg;

  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 6;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 7;

  localparam logic [1:0] REG_POLICY   = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_FRAMES   = 2'd2;

  localparam logic POLICY_MFU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              is_write;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_dirty;
    logic               no_frame;
    logic [CNT_W-1:0]   fault_total;
    logic [CNT_W-1:0]   dirty_write_total;
    logic [CNT_W-1:0]   table_access_total;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FRAME,
    ST_VICT,
    ST_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

FILE: src/page_table_frequency_replacement.sv
// ----------------------------------------------------------------------------
// page_table_frequency_replacement
// Page table with MFU / LFU replacement over a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// Entries sit in a ring of cells that rotates one place a cycle in the lookup and
// victim passes; the head cell is examined and rewritten. An access that hits
// is accepted, makes a lookup pass over every entry and then loads the result
// beat. A fill adds a free frame search, and a replace adds a victim pass. The
// new entry is written into its cell in the result cycle. The ring always makes
// a full turn so entries return to index order. The input stalls until the
// result beat is taken, so the next access is accepted no sooner than the cycle
// after that.
module page_table_frequency_replacement
  import ptfr_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int EW = $clog2(ENTRIES + 1);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCW = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] pg [ENTRIES];
  logic [FW-1:0]        fr [ENTRIES];
  logic                 dt [ENTRIES];
  logic [CNT_W-1:0]     uc [ENTRIES];
  logic [PAGE_BITS-1:0] pg_in [ENTRIES];
  logic [FW-1:0]        fr_in [ENTRIES];
  logic                 dt_in [ENTRIES];
  logic [CNT_W-1:0]     uc_in [ENTRIES];

  state_t state, state_next;
  logic policy;
  logic [CFG_W-1:0] cap_reg, nfr_reg;
  logic [EW-1:0] filled;
  logic [FRAMES-1:0] frame_free;
  logic [CNT_W-1:0] faults, dirties, accesses;
  logic [EW-1:0] step;
  logic [PAGE_BITS-1:0] req_page;
  logic req_wr, found;
  logic [FCW-1:0] fidx;
  logic [EW-1:0] vic;
  logic [CNT_W-1:0] best;
  logic shift;
  logic [PAGE_BITS-1:0] h_pg;
  logic [FW-1:0] h_fr;
  logic h_dt;
  logic [CNT_W-1:0] h_uc;
  logic [EW-1:0] cap, n;
  logic [FCW-1:0] nfr;
  logic out_full;
  logic is_hit;
  logic [EW-1:0] pos;
  logic better;
  logic take;
  logic fill_do;
  logic [EW-1:0] fill_at;
  logic [FW-1:0] fill_fr;

  assign cap = (int'(cap_reg) > ENTRIES) ? EW'(ENTRIES) : EW'(cap_reg);
  assign nfr = (int'(nfr_reg) > FRAMES) ? FCW'(FRAMES) : FCW'(nfr_reg);
  assign n   = filled;
  assign pos = step;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ptfr_cell #(.PW(PAGE_BITS), .FW(FW)) u_cell (
      .clk(clk), .shift(shift), .load(fill_do && (fill_at == EW'(i))),
      .page_in(pg_in[i]), .frame_in(fr_in[i]), .dirty_in(dt_in[i]),
      .count_in(uc_in[i]),
      .page(pg[i]), .frame(fr[i]), .dirty(dt[i]), .count(uc[i]));
  end

  always_comb begin
    for (int i = 0; i < ENTRIES - 1; i++) begin
      pg_in[i] = pg[i+1];
      fr_in[i] = fr[i+1];
      dt_in[i] = dt[i+1];
      uc_in[i] = uc[i+1];
    end
    pg_in[ENTRIES-1] = h_pg;
    fr_in[ENTRIES-1] = h_fr;
    dt_in[ENTRIES-1] = h_dt;
    uc_in[ENTRIES-1] = h_uc;
    if (fill_do) begin
      for (int i = 0; i < ENTRIES; i++) begin
        pg_in[i] = req_page;
        fr_in[i] = fill_fr;
        dt_in[i] = req_wr;
        uc_in[i] = CNT_W'(1);
      end
    end
  end

  assign in_stall  = (state != ST_IDLE) || out_full;
  assign cfg_ready = (state == ST_IDLE) && !out_full;
  assign out_valid = out_full;
  assign is_hit = (pos < n) && !found && (pg[0] == req_page);
  assign better = (policy == POLICY_MFU) ? (uc[0] > best) : (uc[0] < best);
  assign take = (pos < n) && ((pos == '0) || better);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && !in_stall) state_next = ST_LOOK;
      ST_LOOK:  if (pos == EW'(ENTRIES - 1)) begin
        if (found || is_hit) state_next = ST_DONE;
        else if (n < cap) state_next = ST_FRAME;
        else if (n == '0) state_next = ST_DONE;
        else state_next = ST_VICT;
      end
      ST_FRAME: if (fidx >= nfr || frame_free[fidx[FW-1:0]]) state_next = ST_DONE;
      ST_VICT:  if (pos == EW'(ENTRIES - 1)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // head cell path: rotate, rewriting the head on hit
  always_comb begin
    shift = (state == ST_LOOK) || (state == ST_VICT);
    h_pg = pg[0];
    h_fr = fr[0];
    h_dt = dt[0];
    h_uc = uc[0];
    unique case (state)
      ST_LOOK: if (is_hit) begin
        h_uc = sat_inc(uc[0]);
        h_dt = dt[0] | req_wr;
      end
      ST_VICT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      policy <= POLICY_MFU;
      cap_reg <= CFG_W'(64);
      nfr_reg <= CFG_W'(64);
      filled <= '0;
      frame_free <= '1;
      faults <= '0;
      dirties <= '0;
      accesses <= '0;
      out_full <= 1'b0;
      step <= '0;
      found <= 1'b0;
      fidx <= '0;
      vic <= '0;
      best <= '0;
      fill_do <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && !out_stall) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POLICY:   policy <= cfg_data[0];
          REG_CAPACITY: cap_reg <= cfg_data;
          REG_FRAMES:   nfr_reg <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          req_page <= PAGE_BITS'(in_data.page_number);
          req_wr <= in_data.is_write;
          step <= '0;
          found <= 1'b0;
          fidx <= '0;
          out_data <= '0;
        end
        ST_LOOK: begin
          step <= (pos == EW'(ENTRIES - 1)) ? '0 : step + 1'b1;
          if (pos < n && !found) accesses <= sat_inc(accesses);
          if (is_hit) begin
            found <= 1'b1;
            out_data.hit <= 1'b1;
            out_data.frame <= FRAME_W'(fr[0]);
          end
          if (pos == EW'(ENTRIES - 1)) begin
            if (!(found || is_hit) && n >= cap && n == '0) out_data.no_frame <= 1'b1;
          end
        end
        ST_FRAME: begin
          if (fidx >= nfr) out_data.no_frame <= 1'b1;
          else if (frame_free[fidx[FW-1:0]]) begin
            frame_free[fidx[FW-1:0]] <= 1'b0;
            fill_do <= 1'b1;
            fill_at <= n;
            fill_fr <= fidx[FW-1:0];
            filled <= n + 1'b1;
            faults <= sat_inc(faults);
            accesses <= sat_inc(accesses);
            out_data.fault <= 1'b1;
            out_data.frame <= FRAME_W'(fidx);
          end else fidx <= fidx + 1'b1;
        end
        ST_VICT: begin
          step <= step + 1'b1;
          if (pos < n) accesses <= sat_inc(accesses);
          if (take) begin
            best <= uc[0];
            vic <= pos;
            out_data.evicted_page <= PAGE_W'(pg[0]);
            out_data.evicted_dirty <= dt[0];
            out_data.frame <= FRAME_W'(fr[0]);
            fill_fr <= fr[0];
          end
          if (pos == EW'(ENTRIES - 1)) begin
            fill_do <= 1'b1;
            fill_at <= take ? pos : vic;
            out_data.evicted <= 1'b1;
            out_data.fault <= 1'b1;
            faults <= sat_inc(faults);
          end
        end
        ST_DONE: begin
          out_full <= 1'b1;
          fill_do <= 1'b0;
          out_data.fault_total <= faults;
          if (fill_do && out_data.evicted) begin
            out_data.table_access_total <= sat_inc(accesses);
            accesses <= sat_inc(accesses);
            if (out_data.evicted_dirty) begin
              dirties <= sat_inc(dirties);
              out_data.dirty_write_total <= sat_inc(dirties);
            end else out_data.dirty_write_total <= dirties;
          end else begin
            out_data.table_access_total <= accesses;
            out_data.dirty_write_total <= dirties;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/ptfr_cell.sv
// ----------------------------------------------------------------------------
// ptfr_cell
// One table entry in the rotating entry ring.
// ----------------------------------------------------------------------------
module ptfr_cell
  import ptfr_pkg::*;
#(
  parameter int PW = 20,
  parameter int FW = 10
) (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  logic [PW-1:0] page_in,
  input  logic [FW-1:0] frame_in,
  input  logic          dirty_in,
  input  logic [CNT_W-1:0] count_in,
  output logic [PW-1:0] page,
  output logic [FW-1:0] frame,
  output logic          dirty,
  output logic [CNT_W-1:0] count
);

  always_ff @(posedge clk) begin
    if (shift || load) begin
      page  <= page_in;
      frame <= frame_in;
      dirty <= dirty_in;
      count <= count_in;
    end
  end

endmodule

FILE: bench/page_table_frequency_replacement_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_table_frequency_replacement_tb
// Self-checking bench for the MFU / LFU page table. A directed table walks
// empty-table, no-frame, hit, fill and replacement cases through several
// register settings. Random access phases follow, drawn mostly from a page
// pool so hits and replacements occur. Every result beat is checked field by
// field against an in-bench predictor, or against a hand-written directed row.
// ----------------------------------------------------------------------------
module page_table_frequency_replacement_tb;
  import ptfr_pkg::*;

  localparam int NENT    = 64;
  localparam int NFRM    = 64;
  localparam int SETTLE  = 300;
  localparam int POOL_SZ = 96;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       idx;
    logic [CFG_W-1:0] val;
    logic [PAGE_W-1:0] page;
    logic             wr;
    bit               typed;
    rsp_t             exp;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  req_t             in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // page table mirror
  logic [PAGE_W-1:0]  tbl_page [NENT];
  logic [FRAME_W-1:0] tbl_frame[NENT];
  bit                 tbl_dirty[NENT];
  logic [CNT_W-1:0]   tbl_uses [NENT];
  int                 tbl_filled;
  bit                 frame_taken[NFRM];
  logic [CNT_W-1:0]   n_faults, n_dirty_wb, n_tbl_acc;
  logic               mir_policy;
  int                 mir_cap, mir_frames;

  rsp_t               pending_rsp[$];
  int                 n_errors = 0;
  int                 n_results = 0;
  bit                 quiet = 1'b0;
  bit                 held = 1'b0;
  logic [PAGE_W-1:0]  page_pool[POOL_SZ];
  row_t               dir_rows[$];

  page_table_frequency_replacement u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void mirror_reset();
    for (int i = 0; i < NFRM; i++) frame_taken[i] = 1'b0;
    tbl_filled = 0;
    n_faults = '0;
    n_dirty_wb = '0;
    n_tbl_acc = '0;
    mir_policy = POLICY_MFU;
    mir_cap = 64;
    mir_frames = 64;
  endfunction

  function automatic void fill_slot(input int k, input logic [PAGE_W-1:0] page,
                                    input logic [FRAME_W-1:0] f, input logic wr);
    tbl_page[k] = page;
    tbl_frame[k] = f;
    tbl_dirty[k] = wr;
    tbl_uses[k] = CNT_W'(1);
    n_tbl_acc = bump(n_tbl_acc);
    n_faults = bump(n_faults);
  endfunction

  function automatic rsp_t page_lookup(input logic [PAGE_W-1:0] page, input logic wr);
    rsp_t r;
    int   cap, nfr, f, vic;
    bit   found, got;
    logic [CNT_W-1:0] best;
    r = '0;
    cap = (mir_cap > NENT) ? NENT : mir_cap;
    nfr = (mir_frames > NFRM) ? NFRM : mir_frames;
    found = 1'b0;
    for (int i = 0; i < tbl_filled; i++) begin
      n_tbl_acc = bump(n_tbl_acc);
      if (tbl_page[i] == page) begin
        tbl_uses[i] = bump(tbl_uses[i]);
        if (wr) tbl_dirty[i] = 1'b1;
        r.hit = 1'b1;
        r.frame = tbl_frame[i];
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      if (tbl_filled < cap) begin
        got = 1'b0;
        f = 0;
        for (int i = 0; i < nfr; i++) begin
          if (!frame_taken[i]) begin
            f = i;
            got = 1'b1;
            break;
          end
        end
        if (got) begin
          frame_taken[f] = 1'b1;
          fill_slot(tbl_filled, page, f[FRAME_W-1:0], wr);
          tbl_filled++;
          r.fault = 1'b1;
          r.frame = f[FRAME_W-1:0];
        end else begin
          r.no_frame = 1'b1;
        end
      end else if (tbl_filled == 0) begin
        r.no_frame = 1'b1;
      end else begin
        vic = 0;
        best = '0;
        for (int i = 0; i < tbl_filled; i++) begin
          n_tbl_acc = bump(n_tbl_acc);
          if (i == 0 || (mir_policy == POLICY_MFU ? tbl_uses[i] > best
                                                  : tbl_uses[i] < best)) begin
            best = tbl_uses[i];
            vic = i;
          end
        end
        r.evicted = 1'b1;
        r.evicted_page = tbl_page[vic];
        r.evicted_dirty = tbl_dirty[vic];
        if (tbl_dirty[vic]) n_dirty_wb = bump(n_dirty_wb);
        fill_slot(vic, page, tbl_frame[vic], wr);
        r.fault = 1'b1;
        r.frame = tbl_frame[vic];
      end
    end
    r.fault_total = n_faults;
    r.dirty_write_total = n_dirty_wb;
    r.table_access_total = n_tbl_acc;
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POLICY:   mir_policy = val[0];
      REG_CAPACITY: mir_cap = int'(val);
      REG_FRAMES:   mir_frames = int'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the access is accepted
  task automatic send_access(input logic [PAGE_W-1:0] page, input logic wr,
                             input bit typed, input rsp_t exp);
    rsp_t pred;
    int   gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.page_number = page;
    in_data.is_write = wr;
    do @(posedge clk); while (in_stall);
    pred = page_lookup(page, wr);
    pending_rsp.push_back(typed ? exp : pred);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] e,
                             input logic [CNT_W-1:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("hit", e.hit, out_data.hit);
        check_field("fault", e.fault, out_data.fault);
        check_field("frame", e.frame, out_data.frame);
        check_field("evicted", e.evicted, out_data.evicted);
        check_field("evicted_page", e.evicted_page, out_data.evicted_page);
        check_field("evicted_dirty", e.evicted_dirty, out_data.evicted_dirty);
        check_field("no_frame", e.no_frame, out_data.no_frame);
        check_field("fault_total", e.fault_total, out_data.fault_total);
        check_field("dirty_write_total", e.dirty_write_total,
                    out_data.dirty_write_total);
        check_field("table_access_total", e.table_access_total,
                    out_data.table_access_total);
      end
    end
  end

  // receiver stalls: random bursts, one long hold-off to back up the input
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!held && n_results >= 20) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (599) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic row_t reg_row(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, val: val, page: '0, wr: 1'b0, typed: 1'b0, exp: '0};
    return r;
  endfunction

  function automatic row_t acc_row(input logic [PAGE_W-1:0] page, input logic wr,
                                   input bit typed = 1'b0, input rsp_t exp = '0);
    row_t r;
    r = '{kind: ROW_ACCESS, idx: REG_POLICY, val: '0, page: page, wr: wr,
          typed: typed, exp: exp};
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic fault, input logic [FRAME_W-1:0] frame,
                                  input logic no_frame, input int faults, input int acc);
    rsp_t r;
    r = '0;
    r.fault = fault;
    r.frame = frame;
    r.no_frame = no_frame;
    r.fault_total = faults;
    r.table_access_total = acc;
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_cfg[6][3];
    int               per_phase;
    logic [PAGE_W-1:0] pg;

    mirror_reset();
    for (int i = 0; i < POOL_SZ; i++) page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;

    // empty table with zero capacity
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd0));
    dir_rows.push_back(acc_row(20'h00000, 1'b0, 1'b1,
                               mk_rsp(1'b0, 6'd0, 1'b1, 0, 0)));
    // fills, hits, running out of frames
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd3));
    dir_rows.push_back(reg_row(REG_FRAMES, 7'd2));
    dir_rows.push_back(acc_row(20'h00000, 1'b1, 1'b1,
                               mk_rsp(1'b1, 6'd0, 1'b0, 1, 1)));
    dir_rows.push_back(acc_row(20'hFFFFF, 1'b0, 1'b1,
                               mk_rsp(1'b1, 6'd1, 1'b0, 2, 3)));
    dir_rows.push_back(acc_row(20'h00000, 1'b0));
    dir_rows.push_back(acc_row(20'h12345, 1'b0));
    dir_rows.push_back(acc_row(20'hFFFFF, 1'b1));
    // full table, MFU tie goes to the lowest index
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd2));
    dir_rows.push_back(acc_row(20'hABCDE, 1'b1));
    dir_rows.push_back(acc_row(20'h00000, 1'b0));
    // LFU replacement
    dir_rows.push_back(reg_row(REG_POLICY, CFG_W'(POLICY_LFU)));
    dir_rows.push_back(acc_row(20'h55555, 1'b0));
    dir_rows.push_back(acc_row(20'hAAAAA, 1'b1));
    dir_rows.push_back(acc_row(20'h55555, 1'b0));
    // registers above the table and frame limits
    dir_rows.push_back(reg_row(REG_FRAMES, 7'd127));
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd127));
    dir_rows.push_back(acc_row(20'h00001, 1'b1));
    dir_rows.push_back(acc_row(20'h80000, 1'b0));
    // capacity lowered below fill
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd1));
    dir_rows.push_back(acc_row(20'h7FFFF, 1'b0));
    // no frames at all
    dir_rows.push_back(reg_row(REG_FRAMES, 7'd0));
    dir_rows.push_back(reg_row(REG_CAPACITY, 7'd64));
    dir_rows.push_back(acc_row(20'h33333, 1'b1));

    phase_cfg = '{'{CFG_W'(POLICY_MFU), 7'd64, 7'd64},
                  '{CFG_W'(POLICY_LFU), 7'd64, 7'd64},
                  '{CFG_W'(POLICY_MFU), 7'd10, 7'd64},
                  '{CFG_W'(POLICY_LFU), 7'd127, 7'd127},
                  '{CFG_W'(POLICY_MFU), 7'd64, 7'd1},
                  '{CFG_W'(POLICY_LFU), 7'd64, 7'd64}};
    per_phase = 75;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        in_valid = 1'b0;
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_access(dir_rows[i].page, dir_rows[i].wr, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    for (int p = 0; p < 6; p++) begin
      in_valid = 1'b0;
      write_reg(REG_POLICY, phase_cfg[p][0]);
      write_reg(REG_CAPACITY, phase_cfg[p][1]);
      write_reg(REG_FRAMES, phase_cfg[p][2]);
      for (int k = 0; k < per_phase; k++) begin
        if (p == 5 && k >= per_phase - 40) quiet = 1'b1;
        if ($urandom_range(0, 99) < 85) pg = page_pool[$urandom_range(0, POOL_SZ - 1)];
        else pg = PAGE_W'($urandom);
        send_access(pg, 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
    in_valid = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: page_table_frequency_replacement.f
src/ptfr_pkg.sv
src/ptfr_cell.sv
src/page_table_frequency_replacement.sv
bench/page_table_frequency_replacement_tb.sv
